// ----- rtl/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the nearest-neighbor search block.
// ----------------------------------------------------------------------------
package knn_pkg;

   localparam int COORD_W   = 16;
   localparam int NUM_COORD = 8;
   localparam int DIST_W    = 37;
   localparam int IDX_OUT_W = 10;
   localparam int RANK_W    = 4;
   localparam int NCNT_W    = 5;
   localparam int DIMS_W    = 4;
   localparam int PER_W     = 16;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   localparam logic [1:0] REG_NEIGHBOR_COUNT  = 2'd0;
   localparam logic [1:0] REG_DIMS_USED       = 2'd1;
   localparam logic [1:0] REG_PERIODIC_ENABLE = 2'd2;
   localparam logic [1:0] REG_PERIOD_LENGTH   = 2'd3;

   localparam logic [NCNT_W-1:0] NEIGHBOR_COUNT_RST = 5'd2;
   localparam logic [DIMS_W-1:0] DIMS_USED_RST      = 4'd2;
   localparam logic [PER_W-1:0]  PERIOD_LENGTH_RST  = 16'd25736;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [NCNT_W-1:0] neighbor_count;
      logic [DIMS_W-1:0] dims_used;
      logic              periodic_enable;
      logic [PER_W-1:0]  period_length;
   } knn_cfg_type;

   typedef struct packed {
      logic mem_we;
      logic mem_re;
      logic capture_query;
      logic scan_valid;
      logic clear_list;
   } knn_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } knn_status_type;

endpackage

// ----- rtl/knn_if.sv -----
// ----------------------------------------------------------------------------
// knn channel interfaces
// Valid/ready channels for commands and for search results.
// ----------------------------------------------------------------------------
interface knn_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic               new_set;
   logic [9:0]         query_index;
   logic signed [15:0] coord_0;
   logic signed [15:0] coord_1;
   logic signed [15:0] coord_2;
   logic signed [15:0] coord_3;
   logic signed [15:0] coord_4;
   logic signed [15:0] coord_5;
   logic signed [15:0] coord_6;
   logic signed [15:0] coord_7;

   modport source (output valid, command, new_set, query_index, coord_0, coord_1,
                   coord_2, coord_3, coord_4, coord_5, coord_6, coord_7,
                   input ready);
   modport sink (input valid, command, new_set, query_index, coord_0, coord_1,
                 coord_2, coord_3, coord_4, coord_5, coord_6, coord_7,
                 output ready);
endinterface

interface knn_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [3:0]  rank;
   logic [9:0]  neighbor_index;
   logic [36:0] squared_distance;
   logic        last;

   modport source (output valid, status, rank, neighbor_index, squared_distance, last,
                   input ready);
   modport sink (input valid, status, rank, neighbor_index, squared_distance, last,
                 output ready);
endinterface

// ----- rtl/knn_csr.sv -----
// ----------------------------------------------------------------------------
// knn_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module knn_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [knn_pkg::PADDR_W-1:0]   paddr,
   input  logic [knn_pkg::PDATA_W-1:0]   pwdata,
   output logic [knn_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output knn_pkg::knn_cfg_type          cfg
);
   import knn_pkg::*;

   knn_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_NEIGHBOR_COUNT:  cfg_in.neighbor_count  = pwdata[NCNT_W-1:0];
            REG_DIMS_USED:       cfg_in.dims_used       = pwdata[DIMS_W-1:0];
            REG_PERIODIC_ENABLE: cfg_in.periodic_enable = pwdata[0];
            REG_PERIOD_LENGTH:   cfg_in.period_length   = pwdata[PER_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_NEIGHBOR_COUNT:  prdata = PDATA_W'(cfg_ff.neighbor_count);
         REG_DIMS_USED:       prdata = PDATA_W'(cfg_ff.dims_used);
         REG_PERIODIC_ENABLE: prdata = PDATA_W'(cfg_ff.periodic_enable);
         REG_PERIOD_LENGTH:   prdata = PDATA_W'(cfg_ff.period_length);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neighbor_count  <= NEIGHBOR_COUNT_RST;
         cfg_ff.dims_used       <= DIMS_USED_RST;
         cfg_ff.periodic_enable <= 1'b0;
         cfg_ff.period_length   <= PERIOD_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/knn_dp.sv -----
// ----------------------------------------------------------------------------
// knn_dp
// Point memory, distance pipeline and sorted neighbor list.
// ----------------------------------------------------------------------------
module knn_dp #(
   parameter int MAX_POINTS    = 1024,
   parameter int MAX_DIMS      = 8,
   parameter int MAX_NEIGHBORS = 16,
   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int KW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
   localparam int ROW_W = MAX_DIMS * knn_pkg::COORD_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  knn_pkg::knn_cfg_type          cfg,
   input  knn_pkg::knn_cmd_type          cmd,
   input  logic [IW-1:0]                 mem_addr,
   input  logic [ROW_W-1:0]              wr_row,
   input  logic [KW-1:0]                 emit_k,
   output knn_pkg::knn_status_type       status,
   output logic [IW-1:0]                 emit_index,
   output logic [knn_pkg::DIST_W-1:0]    emit_dist
);
   import knn_pkg::*;

   localparam int SQ_W = 2 * COORD_W;

   logic [ROW_W-1:0]   mem [MAX_POINTS];
   logic [ROW_W-1:0]   rd_ff;
   logic [ROW_W-1:0]   query_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IW-1:0]      idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [COORD_W-1:0] mag_ff [MAX_DIMS];
   logic [COORD_W-1:0] mag_in [MAX_DIMS];
   logic [SQ_W-1:0]    sq_ff [MAX_DIMS];
   logic [DIST_W-1:0]  sum_ff, sum_in;
   logic [MAX_DIMS-1:0] dim_used;
   logic [MAX_NEIGHBORS-1:0] lv_ff, lv_in, le;
   logic [DIST_W-1:0]  ld_ff [MAX_NEIGHBORS];
   logic [DIST_W-1:0]  ld_in [MAX_NEIGHBORS];
   logic [IW-1:0]      li_ff [MAX_NEIGHBORS];
   logic [IW-1:0]      li_in [MAX_NEIGHBORS];

   function automatic logic [COORD_W-1:0] wrap_mag(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b,
                                                   input logic wrap_en,
                                                   input logic [PER_W-1:0] len);
      logic signed [COORD_W+2:0] diff, mag, t, len_s;
      diff  = (COORD_W+3)'(a) - (COORD_W+3)'(b);
      mag   = (diff < 0) ? -diff : diff;
      len_s = (COORD_W+3)'({1'b0, len});
      t     = mag;
      if (wrap_en && ((mag <<< 1) > len_s)) begin
         t = (a > b) ? (len_s - diff) : (len_s + diff);
         if (t < 0) begin
            t = -t;
         end
      end
      return t[COORD_W-1:0];
   endfunction

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         dim_used[d] = (cfg.dims_used == '0) ? (d == 0) : (32'(cfg.dims_used) > d);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[mem_addr] <= wr_row;
      end
      if (cmd.mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         mag_in[d] = dim_used[d] ?
                     wrap_mag(query_ff[d*COORD_W +: COORD_W], rd_ff[d*COORD_W +: COORD_W],
                              cfg.periodic_enable, cfg.period_length) : '0;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         sum_in = sum_in + DIST_W'(sq_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_query) begin
         query_ff <= rd_ff;
      end
      idx1_ff <= mem_addr;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      for (int d = 0; d < MAX_DIMS; d++) begin
         mag_ff[d] <= mag_in[d];
         sq_ff[d]  <= SQ_W'(mag_ff[d]) * SQ_W'(mag_ff[d]);
      end
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         le[i] = lv_ff[i] && (ld_ff[i] <= sum_ff);
      end
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         lv_in[i] = lv_ff[i];
         ld_in[i] = ld_ff[i];
         li_in[i] = li_ff[i];
         if (v4_ff && !le[i]) begin
            if (i == 0 || le[(i > 0) ? i - 1 : 0]) begin
               lv_in[i] = 1'b1;
               ld_in[i] = sum_ff;
               li_in[i] = idx4_ff;
            end else begin
               lv_in[i] = lv_ff[(i > 0) ? i - 1 : 0];
               ld_in[i] = ld_ff[(i > 0) ? i - 1 : 0];
               li_in[i] = li_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         ld_ff[i] <= ld_in[i];
         li_ff[i] <= li_in[i];
      end
      if (reset || cmd.clear_list) begin
         lv_ff <= '0;
      end else begin
         lv_ff <= lv_in;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign emit_index       = li_ff[emit_k];
   assign emit_dist        = ld_ff[emit_k];

endmodule

// ----- rtl/knn_ctrl.sv -----
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer for loads, the query scan and the result beats.
// ----------------------------------------------------------------------------
module knn_ctrl #(
   parameter int MAX_POINTS    = 1024,
   parameter int MAX_NEIGHBORS = 16,
   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int CW = $clog2(MAX_POINTS + 1),
   localparam int KW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
   localparam int NW = $clog2(MAX_NEIGHBORS + 1),
   localparam int QW = (CW > 10) ? CW : 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  knn_pkg::knn_cfg_type     cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic                     req_new_set,
   input  logic [9:0]               req_query_index,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_error,
   output logic                     rsp_last,
   output logic [KW-1:0]            emit_k,
   output knn_pkg::knn_cmd_type     cmd,
   input  knn_pkg::knn_status_type  status,
   output logic [IW-1:0]            mem_addr
);
   import knn_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_QREAD = 3'd1;
   localparam logic [2:0] S_QCAP  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_ERR   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] qi_ff, qi_in;
   logic [NW-1:0] n_ff, n_in;
   logic [KW-1:0] k_ff, k_in;
   logic [NW-1:0] want;
   logic          accept, rsp_take, is_last, q_bad;

   assign accept   = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign is_last  = (NW'(k_ff) == n_ff - NW'(1));
   assign q_bad    = (QW'(req_query_index) >= QW'(count_ff)) || (count_ff < CW'(2));

   always_comb begin
      if (cfg.neighbor_count == '0) begin
         want = NW'(1);
      end else if (32'(cfg.neighbor_count) > MAX_NEIGHBORS) begin
         want = NW'(MAX_NEIGHBORS);
      end else begin
         want = NW'(cfg.neighbor_count);
      end
      if (32'(want) > 32'(count_ff) - 32'd1) begin
         want = NW'(count_ff - CW'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      qi_in    = qi_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      cmd      = '0;
      mem_addr = qi_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_error = 1'b0;
      rsp_last  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_command == CMD_LOAD) begin
               if (req_new_set) begin
                  mem_addr   = '0;
                  cmd.mem_we = 1'b1;
                  count_in   = CW'(1);
               end else if (count_ff < CW'(MAX_POINTS)) begin
                  mem_addr   = IW'(count_ff);
                  cmd.mem_we = 1'b1;
                  count_in   = count_ff + CW'(1);
               end
            end else if (req_valid) begin
               cmd.clear_list = 1'b1;
               qi_in = IW'(req_query_index);
               n_in  = want;
               state_in = q_bad ? S_ERR : S_QREAD;
            end
         end
         S_QREAD: begin
            cmd.mem_re = 1'b1;
            state_in   = S_QCAP;
         end
         S_QCAP: begin
            cmd.capture_query = 1'b1;
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            mem_addr       = IW'(scan_ff);
            cmd.mem_re     = 1'b1;
            cmd.scan_valid = (IW'(scan_ff) != qi_ff);
            scan_in        = scan_ff + CW'(1);
            if (scan_ff == count_ff - CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               k_in     = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = is_last;
            if (rsp_ready) begin
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         S_ERR: begin
            rsp_valid = 1'b1;
            rsp_error = 1'b1;
            rsp_last  = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign emit_k = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      scan_ff <= scan_in;
      qi_ff   <= qi_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count above capacity");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last |=> state_ff == S_IDLE)
      else $error("no return to idle after final beat");

   a_emit_n: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> (n_ff != '0) && (NW'(k_ff) < n_ff))
      else $error("result rank out of range");

   a_drain_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> !status.pipe_busy)
      else $error("results shown while pipeline busy");

endmodule

// ----- rtl/knn_euclidean_periodic_search.sv -----
// ----------------------------------------------------------------------------
// knn_euclidean_periodic_search
// Brute-force k-nearest-neighbor search over stored points, squared
// Euclidean distance with optional periodic wrap.
// ----------------------------------------------------------------------------
// A query scans the stored points, one stored point per cycle through the
// point memory read port and a distance pipeline of read, magnitude, square
// and sum registers, then sends the result beats. One command is in work at
// a time. Reset is synchronous and active high; it clears the point count, the
// state, the valid flags and the configuration; the memory needs no clearing.
module knn_euclidean_periodic_search #(
   parameter int MAX_POINTS    = 1024,
   parameter int MAX_DIMS      = 8,
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   knn_req_if.sink                      req_ch,
   knn_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [knn_pkg::PADDR_W-1:0]  paddr,
   input  logic [knn_pkg::PDATA_W-1:0]  pwdata,
   output logic [knn_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);
   import knn_pkg::*;

   localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int KW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int ROW_W = MAX_DIMS * COORD_W;

   knn_cfg_type    cfg;
   knn_cmd_type    cmd;
   knn_status_type status;
   logic [IW-1:0]  mem_addr, emit_index;
   logic [KW-1:0]  emit_k;
   logic [DIST_W-1:0] emit_dist;
   logic           rsp_error;
   logic [NUM_COORD-1:0][COORD_W-1:0] coords;
   logic [ROW_W-1:0] wr_row;

   assign coords = {req_ch.coord_7, req_ch.coord_6, req_ch.coord_5, req_ch.coord_4,
                    req_ch.coord_3, req_ch.coord_2, req_ch.coord_1, req_ch.coord_0};

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         wr_row[d*COORD_W +: COORD_W] = coords[d];
      end
   end

   knn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   knn_dp #(
      .MAX_POINTS    (MAX_POINTS),
      .MAX_DIMS      (MAX_DIMS),
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .mem_addr   (mem_addr),
      .wr_row     (wr_row),
      .emit_k     (emit_k),
      .status     (status),
      .emit_index (emit_index),
      .emit_dist  (emit_dist)
   );

   knn_ctrl #(
      .MAX_POINTS    (MAX_POINTS),
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_command     (req_ch.command),
      .req_new_set     (req_ch.new_set),
      .req_query_index (req_ch.query_index),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_error       (rsp_error),
      .rsp_last        (rsp_ch.last),
      .emit_k          (emit_k),
      .cmd             (cmd),
      .status          (status),
      .mem_addr        (mem_addr)
   );

   assign rsp_ch.status           = rsp_error ? STATUS_ERR : STATUS_OK;
   assign rsp_ch.rank             = rsp_error ? '0 : RANK_W'(emit_k);
   assign rsp_ch.neighbor_index   = rsp_error ? '0 : IDX_OUT_W'(emit_index);
   assign rsp_ch.squared_distance = rsp_error ? '0 : emit_dist;

endmodule
